// ===== rtl/core/msb_pkg.sv =====
// ---------------------------------------------------------------------------
// msb_pkg
// Shared types and codes for the multi-stack shared buffer.
// ---------------------------------------------------------------------------
`default_nettype none

package msb_pkg;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // free list control
  typedef struct packed {
    logic rd_en;    // fetch slot at top of free list
    logic alloc;    // take that slot
    logic recycle;  // return a slot
  } fl_ctrl_t;

  // slot store control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ss_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/msb_slot_store.sv =====
// ---------------------------------------------------------------------------
// msb_slot_store
// Value and link memories, one write port and one registered read port each.
// ---------------------------------------------------------------------------
`default_nettype none

module msb_slot_store #(
  parameter int SLOTS     = 64,
  parameter int DATA_BITS = 32
) (
  input  wire                        clk,
  input  msb_pkg::ss_ctrl_t          ctrl,
  input  wire  [$clog2(SLOTS)-1:0]   rd_addr,
  input  wire  [$clog2(SLOTS)-1:0]   wr_addr,
  input  wire  [DATA_BITS-1:0]       wr_data,
  input  wire  [$clog2(SLOTS)-1:0]   wr_next,
  output logic [DATA_BITS-1:0]       rd_data,
  output logic [$clog2(SLOTS)-1:0]   rd_next
);

  localparam int IW = $clog2(SLOTS);

  logic [DATA_BITS-1:0] data_mem [SLOTS];
  logic [IW-1:0]        next_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      data_mem[wr_addr] <= wr_data;
      next_mem[wr_addr] <= wr_next;
    end
    if (ctrl.rd_en) begin
      rd_data <= data_mem[rd_addr];
      rd_next <= next_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/msb_free_list.sv =====
// ---------------------------------------------------------------------------
// msb_free_list
// Free-slot stack in a memory with a fill count. Entries below the low-water
// mark were never overwritten and read as their own index.
// ---------------------------------------------------------------------------
`default_nettype none

module msb_free_list #(
  parameter int SLOTS = 64
) (
  input  wire                          clk,
  input  wire                          rst,
  input  msb_pkg::fl_ctrl_t            ctrl,
  input  wire  [$clog2(SLOTS)-1:0]     recycle_slot,
  output logic [$clog2(SLOTS)-1:0]     alloc_slot,
  output logic                         none_free,
  output logic                         all_free
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  logic [IW-1:0] mem [SLOTS];
  logic [CW-1:0] count;
  logic [CW-1:0] low_mark;
  logic [CW-1:0] count_dec;
  logic [IW-1:0] rd_q;
  logic [IW-1:0] addr_q;
  logic          fresh_q;

  assign count_dec  = count - CW'(1);
  assign none_free  = (count == '0);
  assign all_free   = (count >= CW'(SLOTS));
  assign alloc_slot = fresh_q ? addr_q : rd_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= CW'(SLOTS);
      low_mark <= CW'(SLOTS);
    end else if (ctrl.alloc) begin
      count <= count_dec;
      if (count_dec < low_mark) begin
        low_mark <= count_dec;
      end
    end else if (ctrl.recycle) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.recycle) begin
      mem[count[IW-1:0]] <= recycle_slot;
    end
    if (ctrl.rd_en) begin
      rd_q    <= mem[count_dec[IW-1:0]];
      addr_q  <= count_dec[IW-1:0];
      fresh_q <= (count_dec < low_mark);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/multi_stack_shared_buffer.sv =====
// ---------------------------------------------------------------------------
// multi_stack_shared_buffer
// Several LIFO stacks linked through one shared slot store, with a free list.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+---------------------------
//  in      | input     | in_valid / in_stall | op, stack_id, push_value
//  out     | output    | out_valid/out_stall | status, pop_value
//
//  Each word: accept plus memory read in ST_IDLE, then update and write
//  back of the slot, link and free-list RAMs (one read port each) in ST_EXEC.
//  in_stall is high during the update cycle; the update waits while a
//  finished result is stalled in the output register.
//  Reset: all stacks empty, all slots free; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_stack_shared_buffer #(
  parameter int NUM_STACKS = 4,
  parameter int SLOTS      = 64,
  parameter int DATA_BITS  = 32
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                op,
  input  wire  [1:0]         stack_id,
  input  wire  signed [31:0] push_value,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] pop_value
);

  localparam int IW = $clog2(SLOTS);
  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  msb_pkg::state_t   state, state_next;
  msb_pkg::fl_ctrl_t fl_ctrl;
  msb_pkg::ss_ctrl_t ss_ctrl;

  logic [IW-1:0] top_idx [NUM_STACKS];
  logic          top_vld [NUM_STACKS];

  logic          accept, finish;
  logic [6:0]    id_ext;
  logic [SW-1:0] id_sel;
  logic          id_ok, cur_vld, push_ok, pop_ok;
  logic [IW-1:0] cur_idx;
  logic          none_free, all_free;
  logic [IW-1:0] alloc_slot;
  logic [DATA_BITS-1:0] rd_data;
  logic [IW-1:0] rd_next;
  logic [DATA_BITS-1:0] wr_data;
  logic [IW-1:0] wr_next;
  logic [63:0]   val_ext, rd_ext;

  logic                 op_q, ok_q, cur_vld_q;
  logic [SW-1:0]        id_q;
  logic [IW-1:0]        cur_idx_q;
  logic [DATA_BITS-1:0] val_q;
  logic [1:0]           status_q;

  assign id_ext  = 7'(stack_id);
  assign id_sel  = id_ext[SW-1:0];
  assign id_ok   = (32'(stack_id) < NUM_STACKS);
  assign cur_vld = id_ok && top_vld[id_sel];
  assign cur_idx = top_idx[id_sel];
  assign push_ok = (op == msb_pkg::OP_PUSH) && id_ok && !none_free;
  assign pop_ok  = (op == msb_pkg::OP_POP) && cur_vld && !all_free;

  assign val_ext = {32'b0, push_value};
  assign rd_ext  = 64'(rd_data);
  assign wr_next = cur_vld_q ? cur_idx_q : alloc_slot;

  always_comb begin
    state_next = state;
    case (state)
      msb_pkg::ST_IDLE: if (in_valid) state_next = msb_pkg::ST_EXEC;
      msb_pkg::ST_EXEC: if (!out_valid || !out_stall) state_next = msb_pkg::ST_IDLE;
      default:          state_next = msb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall        = 1'b1;
    accept          = 1'b0;
    finish          = 1'b0;
    fl_ctrl         = '0;
    ss_ctrl         = '0;
    case (state)
      msb_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        accept        = in_valid;
        fl_ctrl.rd_en = in_valid && push_ok;
        ss_ctrl.rd_en = in_valid && pop_ok;
      end
      msb_pkg::ST_EXEC: begin
        finish          = !out_valid || !out_stall;
        fl_ctrl.alloc   = finish && ok_q && (op_q == msb_pkg::OP_PUSH);
        fl_ctrl.recycle = finish && ok_q && (op_q == msb_pkg::OP_POP);
        ss_ctrl.wr_en   = fl_ctrl.alloc;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= op;
      ok_q      <= push_ok || pop_ok;
      id_q      <= id_sel;
      cur_vld_q <= cur_vld;
      cur_idx_q <= cur_idx;
      val_q     <= val_ext[DATA_BITS-1:0];
      if (op == msb_pkg::OP_PUSH) begin
        status_q <= push_ok ? msb_pkg::STATUS_DONE : msb_pkg::STATUS_FULL;
      end else begin
        status_q <= pop_ok ? msb_pkg::STATUS_DONE : msb_pkg::STATUS_EMPTY;
      end
    end
  end

  assign wr_data = val_q;

  // stack top pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        top_vld[i] <= 1'b0;
      end
    end else if (fl_ctrl.alloc) begin
      top_vld[id_q] <= 1'b1;
      top_idx[id_q] <= alloc_slot;
    end else if (fl_ctrl.recycle) begin
      top_vld[id_q] <= (rd_next != cur_idx_q);
      top_idx[id_q] <= rd_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status    <= status_q;
      pop_value <= fl_ctrl.recycle ? signed'(rd_ext[31:0]) : 32'sd0;
    end
  end

  msb_free_list #(
    .SLOTS (SLOTS)
  ) u_free (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (fl_ctrl),
    .recycle_slot (cur_idx_q),
    .alloc_slot   (alloc_slot),
    .none_free    (none_free),
    .all_free     (all_free)
  );

  msb_slot_store #(
    .SLOTS     (SLOTS),
    .DATA_BITS (DATA_BITS)
  ) u_store (
    .clk     (clk),
    .ctrl    (ss_ctrl),
    .rd_addr (cur_idx),
    .wr_addr (alloc_slot),
    .wr_data (wr_data),
    .wr_next (wr_next),
    .rd_data (rd_data),
    .rd_next (rd_next)
  );

endmodule

`default_nettype wire

// ===== rtl/core/msb_checker.sv =====
// ---------------------------------------------------------------------------
// msb_checker
// Port-level checks for the multi-stack shared buffer, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module msb_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [1:0]  status,
  input wire [31:0] pop_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(pop_value))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("word accepted while previous one in flight");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == msb_pkg::STATUS_DONE || status == msb_pkg::STATUS_FULL
                  || status == msb_pkg::STATUS_EMPTY)
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != msb_pkg::STATUS_DONE |-> pop_value == 32'd0)
    else $error("nonzero value on failed operation");

endmodule

bind multi_stack_shared_buffer msb_checker u_msb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .pop_value (pop_value)
);

`default_nettype wire
